### rtl/section_latency_profiler_assert.svh
// ----------------------------------------------------------------------------
// Section latency profiler assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SECTION_LATENCY_PROFILER_ASSERT_SVH
`define SECTION_LATENCY_PROFILER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("section_latency_profiler: implication failed");
// next-cycle implication
`define SLP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("section_latency_profiler: next-cycle implication failed");
`else
`define SLP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SLP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// Section latency profiler package
// Widths, command and status codes, transfer types and a shared helper.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int SECTIONS_DEF      = 16;
	localparam int EXTREME_SLOTS_DEF = 3;

	localparam int ID_W    = 4;
	localparam int TICK_W  = 63;
	localparam int COUNT_W = 32;

	localparam logic [TICK_W-1:0]  MASK63 = {TICK_W{1'b1}};
	localparam logic [COUNT_W-1:0] MAX32  = {COUNT_W{1'b1}};

	// command codes
	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_END    = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_RUNNING     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN     = 2'd2;
	localparam logic [1:0] ST_NOT_RUNNING = 2'd3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ID_W-1:0]   section_id;
		logic [TICK_W-1:0] timestamp;
	} slp_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [TICK_W-1:0]  duration;
		logic [COUNT_W-1:0] sample_count;
		logic [TICK_W-1:0]  total_ticks;
		logic [TICK_W-1:0]  trimmed_total;
		logic [COUNT_W-1:0] trimmed_count;
		logic [TICK_W-1:0]  shortest;
		logic [TICK_W-1:0]  longest;
	} slp_rsp_t;

	// controller to datapath commands, one per phase
	typedef struct packed {
		logic load;
		logic decide;
		logic scan;
		logic update;
		logic stat;
		logic fin1;
		logic fin2;
		logic fin3;
	} slp_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic last_slot;
	} slp_sts_t;

	// saturating add of two tick values
	function automatic logic [TICK_W-1:0] sat_add63(input logic [TICK_W-1:0] a,
			input logic [TICK_W-1:0] b);
		logic [TICK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TICK_W] ? MASK63 : s[TICK_W-1:0];
	endfunction

endpackage

### rtl/slp_ctrl.sv
// ----------------------------------------------------------------------------
// Section latency profiler controller
// Sequences read, worst-slot scan, update, statistics scan and trimming.
// ----------------------------------------------------------------------------
module slp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output slp_pkg::slp_ctl_t ctl,
	input  slp_pkg::slp_sts_t sts
);
	import slp_pkg::*;

	`include "section_latency_profiler_assert.svh"

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_STAT   = 3'd4;
	localparam logic [2:0] S_FIN1   = 3'd5;
	localparam logic [2:0] S_FIN2   = 3'd6;
	localparam logic [2:0] S_FIN3   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       done_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (start) state_nx = S_READ;
			S_READ:   state_nx = S_SCAN;
			S_SCAN:   if (sts.last_slot) state_nx = S_UPDATE;
			S_UPDATE: state_nx = S_STAT;
			S_STAT:   if (sts.last_slot) state_nx = S_FIN1;
			S_FIN1:   state_nx = S_FIN2;
			S_FIN2:   state_nx = S_FIN3;
			S_FIN3:   state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// hold state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == S_FIN3);
		end
	end

	// decode phase commands
	always_comb begin
		ctl.load   = (state_q == S_IDLE) && start;
		ctl.decide = (state_q == S_READ);
		ctl.scan   = (state_q == S_SCAN);
		ctl.update = (state_q == S_UPDATE);
		ctl.stat   = (state_q == S_STAT);
		ctl.fin1   = (state_q == S_FIN1);
		ctl.fin2   = (state_q == S_FIN2);
		ctl.fin3   = (state_q == S_FIN3);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`SLP_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`SLP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy && $past(ctl.fin3))

endmodule

### rtl/slp_datapath.sv
// ----------------------------------------------------------------------------
// Section latency profiler datapath
// Section record memory, flags, slot scans and trimmed statistics.
// ----------------------------------------------------------------------------
module slp_datapath #(
	parameter int SECTIONS      = slp_pkg::SECTIONS_DEF,
	parameter int EXTREME_SLOTS = slp_pkg::EXTREME_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slp_pkg::slp_req_t req,
	input  slp_pkg::slp_ctl_t ctl,
	output slp_pkg::slp_sts_t sts,
	output slp_pkg::slp_rsp_t rsp
);
	import slp_pkg::*;

	localparam int IDX_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int SLOT_W = (EXTREME_SLOTS > 1) ? $clog2(EXTREME_SLOTS) : 1;
	localparam int FILL_W = $clog2(EXTREME_SLOTS + 1);
	localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(EXTREME_SLOTS);
	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(EXTREME_SLOTS - 1);
	localparam logic [COUNT_W-1:0] TRIM_MIN  = COUNT_W'(2 * EXTREME_SLOTS);
	localparam logic [COUNT_W-1:0] TRIM_SUB  = COUNT_W'(2 * (EXTREME_SLOTS - 1));

	typedef struct packed {
		logic [TICK_W-1:0]                    start;
		logic [COUNT_W-1:0]                   count;
		logic [TICK_W-1:0]                    sum;
		logic [EXTREME_SLOTS-1:0][TICK_W-1:0] shorts;
		logic [EXTREME_SLOTS-1:0][TICK_W-1:0] longs;
		logic [FILL_W-1:0]                    sfill;
		logic [FILL_W-1:0]                    lfill;
	} rec_t;

	rec_t mem [SECTIONS];
	rec_t rd_q;
	rec_t rec_q;
	rec_t rec_nx;

	logic [SECTIONS-1:0] known_q;
	logic [SECTIONS-1:0] running_q;

	logic [1:0]        cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              inr_q;
	logic [TICK_W-1:0] ts_q;

	logic [1:0]        status_q;
	logic [TICK_W-1:0] dur_q;
	logic              valid_q;
	logic              begin_q;
	logic              begin_new_q;
	logic              end_q;
	logic              clear_q;

	logic [1:0]        status_nx;
	logic              valid_nx;
	logic              begin_nx;
	logic              begin_new_nx;
	logic              end_nx;
	logic              clear_nx;

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] wsh_q;
	logic [SLOT_W-1:0] wlg_q;
	logic [TICK_W-1:0] wsh_val_q;
	logic [TICK_W-1:0] wlg_val_q;

	logic [TICK_W-1:0] lo_q;
	logic [TICK_W-1:0] hi_q;
	logic [TICK_W-1:0] sumlo_q;
	logic [TICK_W-1:0] sumhi_q;
	logic [TICK_W-1:0] dlo_q;
	logic [TICK_W-1:0] dhi_q;
	logic [TICK_W-1:0] rem_q;
	slp_rsp_t          rsp_q;

	logic              known_rd;
	logic              running_rd;
	logic [TICK_W-1:0] short_v;
	logic [TICK_W-1:0] long_v;

	assign known_rd   = inr_q && known_q[idx_q];
	assign running_rd = inr_q && running_q[idx_q];
	assign short_v    = rec_q.shorts[slot_q];
	assign long_v     = rec_q.longs[slot_q];
	assign sts.last_slot = (slot_q == SLOT_LAST);

	// record memory: read on transfer, write back in the update phase
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_q <= mem[IDX_W'(req.section_id)];
		end
		if (ctl.update && (begin_q || end_q)) begin
			mem[idx_q] <= rec_nx;
		end
	end

	// section flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q   <= '0;
			running_q <= '0;
		end else if (ctl.update) begin
			if (clear_q) begin
				known_q   <= '0;
				running_q <= '0;
			end
			if (begin_q) begin
				known_q[idx_q]   <= 1'b1;
				running_q[idx_q] <= 1'b1;
			end
			if (end_q) begin
				running_q[idx_q] <= 1'b0;
			end
		end
	end

	// decide actions from command and flags
	always_comb begin
		begin_nx     = 1'b0;
		begin_new_nx = 1'b0;
		end_nx       = 1'b0;
		clear_nx     = 1'b0;
		valid_nx     = known_rd;
		status_nx    = ST_OK;
		if (cmd_q == CMD_CLEAR) begin
			clear_nx = 1'b1;
			valid_nx = 1'b0;
		end else if (!inr_q) begin
			status_nx = ST_UNKNOWN;
		end else begin
			case (cmd_q)
				CMD_BEGIN: begin
					if (running_rd) begin
						status_nx = ST_RUNNING;
					end else begin
						begin_nx     = 1'b1;
						begin_new_nx = !known_rd;
						valid_nx     = 1'b1;
					end
				end
				CMD_END: begin
					if (!known_rd) begin
						status_nx = ST_UNKNOWN;
					end else if (!running_rd) begin
						status_nx = ST_NOT_RUNNING;
					end else begin
						end_nx = 1'b1;
					end
				end
				CMD_REPORT: begin
					if (!known_rd) status_nx = ST_UNKNOWN;
				end
				default: status_nx = ST_OK;
			endcase
		end
	end

	// hold decided actions for the rest of the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q     <= 1'b0;
			begin_new_q <= 1'b0;
			end_q       <= 1'b0;
			clear_q     <= 1'b0;
			valid_q     <= 1'b0;
			status_q    <= ST_OK;
		end else if (ctl.decide) begin
			begin_q     <= begin_nx;
			begin_new_q <= begin_new_nx;
			end_q       <= end_nx;
			clear_q     <= clear_nx;
			valid_q     <= valid_nx;
			status_q    <= status_nx;
		end
	end

	// next record contents
	always_comb begin
		rec_nx = rec_q;
		if (begin_new_q) begin
			rec_nx.count = '0;
			rec_nx.sum   = '0;
			rec_nx.sfill = '0;
			rec_nx.lfill = '0;
			for (int i = 0; i < EXTREME_SLOTS; i++) begin
				rec_nx.shorts[i] = MASK63;
				rec_nx.longs[i]  = '0;
			end
		end
		if (begin_q) begin
			rec_nx.start = ts_q;
		end
		if (end_q) begin
			if (rec_q.count != MAX32) rec_nx.count = rec_q.count + COUNT_W'(1);
			rec_nx.sum = sat_add63(rec_q.sum, dur_q);
			if (rec_q.sfill != FILL_FULL) begin
				rec_nx.shorts[SLOT_W'(rec_q.sfill)] = dur_q;
				rec_nx.sfill = rec_q.sfill + FILL_W'(1);
			end else if (dur_q < wsh_val_q) begin
				rec_nx.shorts[wsh_q] = dur_q;
			end
			if (rec_q.lfill != FILL_FULL) begin
				rec_nx.longs[SLOT_W'(rec_q.lfill)] = dur_q;
				rec_nx.lfill = rec_q.lfill + FILL_W'(1);
			end else if (dur_q > wlg_val_q) begin
				rec_nx.longs[wlg_q] = dur_q;
			end
		end
	end

	// working registers: capture, scans and trimming
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.cmd;
			idx_q <= IDX_W'(req.section_id);
			inr_q <= (32'(req.section_id) < 32'(SECTIONS));
			ts_q  <= req.timestamp;
		end
		if (ctl.decide) begin
			rec_q     <= rd_q;
			dur_q     <= end_nx ? (ts_q - rd_q.start) : '0;
			slot_q    <= '0;
			wsh_q     <= '0;
			wlg_q     <= '0;
			wsh_val_q <= rd_q.shorts[0];
			wlg_val_q <= rd_q.longs[0];
		end
		// find worst kept slot, lowest index on ties
		if (ctl.scan) begin
			if (short_v > wsh_val_q) begin
				wsh_q     <= slot_q;
				wsh_val_q <= short_v;
			end
			if (long_v < wlg_val_q) begin
				wlg_q     <= slot_q;
				wlg_val_q <= long_v;
			end
			if (!sts.last_slot) slot_q <= slot_q + SLOT_W'(1);
			else slot_q <= '0;
		end
		if (ctl.update) begin
			rec_q   <= rec_nx;
			slot_q  <= '0;
			lo_q    <= MASK63;
			hi_q    <= '0;
			sumlo_q <= '0;
			sumhi_q <= '0;
		end
		// accumulate extremes and slot sums
		if (ctl.stat) begin
			if (short_v < lo_q) lo_q <= short_v;
			if (long_v > hi_q) hi_q <= long_v;
			sumlo_q <= sat_add63(sumlo_q, short_v);
			sumhi_q <= sat_add63(sumhi_q, long_v);
			if (!sts.last_slot) slot_q <= slot_q + SLOT_W'(1);
		end
		if (ctl.fin1) begin
			dlo_q <= sumlo_q - lo_q;
			dhi_q <= sumhi_q - hi_q;
		end
		if (ctl.fin2) begin
			rem_q <= sat_add63(dlo_q, dhi_q);
		end
		// assemble result
		if (ctl.fin3) begin
			rsp_q.status   <= status_q;
			rsp_q.duration <= dur_q;
			if (valid_q) begin
				rsp_q.sample_count <= rec_q.count;
				rsp_q.total_ticks  <= rec_q.sum;
				rsp_q.shortest     <= lo_q;
				rsp_q.longest      <= hi_q;
				if (rec_q.count >= TRIM_MIN) begin
					rsp_q.trimmed_total <= (rem_q > rec_q.sum) ? '0 : rec_q.sum - rem_q;
					rsp_q.trimmed_count <= rec_q.count - TRIM_SUB;
				end else begin
					rsp_q.trimmed_total <= rec_q.sum;
					rsp_q.trimmed_count <= rec_q.count;
				end
			end else begin
				rsp_q.sample_count  <= '0;
				rsp_q.total_ticks   <= '0;
				rsp_q.shortest      <= MASK63;
				rsp_q.longest       <= '0;
				rsp_q.trimmed_total <= '0;
				rsp_q.trimmed_count <= '0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/section_latency_profiler.sv
// ----------------------------------------------------------------------------
// Section latency profiler: per-section latency totals with trimmed extremes.
// Each command runs a read, a worst-slot scan, an update, a statistics scan
// and three finishing steps before the done strobe; busy stays high until the
// last finishing step, so a new command is accepted only while idle.
// Reset: arst_n clears all section flags at once, no clearing pass; results
// cannot be stalled; rsp is valid while done is high and held until the next.
// ----------------------------------------------------------------------------
module section_latency_profiler #(
	parameter int SECTIONS      = slp_pkg::SECTIONS_DEF,
	parameter int EXTREME_SLOTS = slp_pkg::EXTREME_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  slp_pkg::slp_req_t req,
	output logic              done,
	output slp_pkg::slp_rsp_t rsp
);
	import slp_pkg::*;

	`include "section_latency_profiler_assert.svh"

	slp_ctl_t ctl;
	slp_sts_t sts;

	// sequence the phases of one command
	slp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	// hold section records and compute statistics
	slp_datapath #(
		.SECTIONS      (SECTIONS),
		.EXTREME_SLOTS (EXTREME_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

	`SLP_ASSERT_IMP(a_err_no_dur, clk, arst_n, done && (rsp.status != ST_OK), rsp.duration == '0)
	`SLP_ASSERT_IMP(a_trim_le_count, clk, arst_n, done, rsp.trimmed_count <= rsp.sample_count)

endmodule
